/* hw/rtl/xcfd_pkg.sv */
// ----------------------------------------------------------------------------
// XOR checksum frame decoder package
// Shared types, byte codes and phase encoding for the frame decoder.
// ----------------------------------------------------------------------------
package xcfd_pkg;

	localparam logic [7:0] HDR_MARK  = 8'h89;
	localparam logic [7:0] ACK_BYTE  = 8'h06;
	localparam logic [7:0] ALT_PRE_A = 8'h00;
	localparam logic [7:0] ALT_PRE_B = 8'h3E;
	localparam logic [7:0] SUM_BIAS  = 8'd7;

	typedef enum logic [2:0] {
		PH_START,
		PH_MARK,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CHECK,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_PREFIX = 3'd2,
		ST_LENGTH = 3'd3,
		ST_SUM    = 3'd4
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} item_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  payload_byte;
		status_t     frame_status;
		logic [7:0]  command_id;
		logic        ack_seen;
		logic [15:0] payload_length;
		logic [7:0]  received_sum;
		logic [7:0]  computed_sum;
	} result_t;

endpackage

/* hw/rtl/xcfd_in_reg.sv */
// ----------------------------------------------------------------------------
// Input register
// Captures one input transaction per cycle whenever the pipeline advances.
// ----------------------------------------------------------------------------
module xcfd_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          in_valid,
	input  xcfd_pkg::item_t in_item,
	output logic          valid_s1,
	output xcfd_pkg::item_t item_s1
);
	import xcfd_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* hw/rtl/xcfd_parser.sv */
// ----------------------------------------------------------------------------
// Frame parser
// Holds the frame state and works out the result of one byte in a single step.
// ----------------------------------------------------------------------------
module xcfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  xcfd_pkg::item_t   item,
	output logic              res_valid,
	output xcfd_pkg::result_t res
);
	import xcfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic        ack_q, ack_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  xor_q, xor_d;
	logic [1:0]  hdr_q, hdr_d;

	logic        done;
	logic        status_hit;
	logic        payload_hit;
	status_t     status;
	logic [7:0]  rsum;
	logic [7:0]  csum;
	logic [7:0]  b;
	logic        eob;

	assign b   = item.in_byte;
	assign eob = item.end_of_buffer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			ack_q   <= 1'b0;
			cmd_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			xor_q   <= '0;
			hdr_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			ack_q   <= ack_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			xor_q   <= xor_d;
			hdr_q   <= hdr_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		ack_d       = ack_q;
		cmd_d       = cmd_q;
		len_d       = len_q;
		cnt_d       = cnt_q;
		xor_d       = xor_q;
		hdr_d       = hdr_q;
		done        = 1'b0;
		status_hit  = 1'b0;
		payload_hit = 1'b0;
		status      = ST_OK;
		rsum        = '0;
		csum        = xor_q + SUM_BIAS;

		case (phase_q)
			PH_START: begin
				// Every frame starts from cleared fields.
				ack_d = 1'b0;
				cmd_d = '0;
				len_d = '0;
				cnt_d = '0;
				xor_d = '0;
				hdr_d = '0;
				if (b == HDR_MARK) begin
					xor_d   = HDR_MARK;
					phase_d = PH_HEADER;
					if (eob) begin
						status_hit = 1'b1;
						status     = ST_SHORT;
					end
				end else if (b inside {ACK_BYTE, ALT_PRE_A, ALT_PRE_B}) begin
					ack_d   = (b == ACK_BYTE);
					phase_d = PH_MARK;
					if (eob) begin
						status_hit = 1'b1;
						status     = ST_SHORT;
					end
				end else begin
					status_hit = 1'b1;
					status     = ST_PREFIX;
				end
			end
			PH_MARK: begin
				if (b == HDR_MARK) begin
					xor_d   = HDR_MARK;
					phase_d = PH_HEADER;
					if (eob) begin
						status_hit = 1'b1;
						status     = ST_SHORT;
					end
				end else begin
					ack_d      = 1'b0;
					status_hit = 1'b1;
					status     = ST_PREFIX;
				end
			end
			PH_HEADER: begin
				xor_d = xor_q ^ b;
				case (hdr_q)
					2'd0: cmd_d = b;
					2'd1: len_d = {8'h00, b};
					default: begin
						len_d   = {b, len_q[7:0]};
						phase_d = ({b, len_q[7:0]} != 16'd0) ? PH_PAYLOAD : PH_CHECK;
					end
				endcase
				if (hdr_q != 2'd3) begin
					hdr_d = hdr_q + 2'd1;
				end
				if (eob) begin
					status_hit = 1'b1;
					status     = ST_SHORT;
				end
			end
			PH_PAYLOAD: begin
				xor_d = xor_q ^ b;
				cnt_d = cnt_q + 16'd1;
				if (eob) begin
					status_hit = 1'b1;
					status     = ST_LENGTH;
				end else begin
					payload_hit = 1'b1;
					if (cnt_d == len_q) begin
						phase_d = PH_CHECK;
					end
				end
			end
			PH_CHECK: begin
				status_hit = 1'b1;
				status     = (b == csum) ? ST_OK : ST_SUM;
				rsum       = b;
			end
			default: begin
				done = 1'b1;
			end
		endcase

		if (status_hit) begin
			done = 1'b1;
		end
		if (eob) begin
			phase_d = PH_START;
		end else if (done) begin
			phase_d = PH_DRAIN;
		end

		res_valid          = status_hit || payload_hit;
		res.result_kind    = status_hit ? KIND_STATUS : KIND_PAYLOAD;
		res.payload_byte   = payload_hit ? b : 8'h00;
		res.frame_status   = status_hit ? status : ST_OK;
		res.command_id     = cmd_d;
		res.ack_seen       = ack_d;
		res.payload_length = len_d;
		res.received_sum   = rsum;
		res.computed_sum   = (phase_q == PH_CHECK) ? csum : 8'h00;
	end

	// A payload transaction can only come out of the payload phase.
	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res_valid && res.result_kind == KIND_PAYLOAD) |-> phase_q == PH_PAYLOAD)
		else $error("payload result outside payload phase");

	// The last byte of a buffer always returns the parser to the start.
	a_eob_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && item.end_of_buffer) |=> phase_q == PH_START)
		else $error("parser did not restart after buffer end");

	// Nothing is produced while draining the rest of a buffer.
	a_drain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DRAIN) |-> !res_valid)
		else $error("result produced while draining");

	a_ok_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.result_kind == KIND_STATUS && res.frame_status == ST_OK)
		|-> res.received_sum == res.computed_sum)
		else $error("ok status with differing checksums");

endmodule

/* hw/rtl/xcfd_out_reg.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module xcfd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              load,
	input  xcfd_pkg::result_t res,
	output logic              out_valid,
	output xcfd_pkg::result_t res_q
);
	import xcfd_pkg::*;

	// The register only advances when it is empty or being emptied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_q <= res;
		end
	end

endmodule

/* hw/rtl/xor_checksum_frame_decoder.sv */
// ----------------------------------------------------------------------------
// XOR checksum frame decoder
// Parses length-prefixed reply frames byte by byte, passes payload bytes on
// and reports one status per reply buffer.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   in_byte, end_of_buffer
//   out      source     out_valid / out_ready result_kind .. computed_sum
//
// One byte is accepted every cycle while the result is not stalled.
// The rate is set by the single-step parser between input and result register.
// Reset clears the parser to expect the first prefix byte; no result is held.
// A stalled result holds in_ready low, which freezes the whole pipeline.
// ----------------------------------------------------------------------------
module xor_checksum_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  frame_status,
	output logic [7:0]  command_id,
	output logic        ack_seen,
	output logic [15:0] payload_length,
	output logic [7:0]  received_sum,
	output logic [7:0]  computed_sum
);
	import xcfd_pkg::*;

	logic    advance;
	logic    valid_s1;
	item_t   in_item;
	item_t   item_s1;
	logic    res_valid;
	result_t res;
	result_t res_q;

	assign advance  = !(out_valid && !out_ready);
	assign in_ready = advance;
	assign in_item  = '{in_byte: in_byte, end_of_buffer: end_of_buffer};

	xcfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (in_valid),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	xcfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (valid_s1 && advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	xcfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.load      (valid_s1 && res_valid),
		.res       (res),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign result_kind    = res_q.result_kind;
	assign payload_byte   = res_q.payload_byte;
	assign frame_status   = res_q.frame_status;
	assign command_id     = res_q.command_id;
	assign ack_seen       = res_q.ack_seen;
	assign payload_length = res_q.payload_length;
	assign received_sum   = res_q.received_sum;
	assign computed_sum   = res_q.computed_sum;

endmodule
